>>> rtl/core/mmcs_pkg.sv
// Shared types, constants and command/status structs for the contrast stretch block.
package mmcs_pkg;

  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  typedef enum logic {
    KIND_SCAN = 1'b0,
    KIND_MAP  = 1'b1
  } kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] sample;
    logic       frame_end;
  } mmcs_in_t;

  typedef struct packed {
    logic [7:0] stretched;
    logic       last_out;
  } mmcs_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE
  } mmcs_state_t;

  typedef struct packed {
    logic scan;
    logic load;
    logic step;
    logic write;
  } mmcs_cmd_t;

  typedef struct packed {
    logic direct;
    logic out_free;
  } mmcs_status_t;

endpackage

>>> rtl/core/mmcs_ctrl.sv
// Controller state machine: accepts requests and sequences the divider and output write.
module mmcs_ctrl import mmcs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         src_valid,
  input  logic         src_kind,
  output logic         src_stall,
  input  mmcs_status_t status,
  output mmcs_cmd_t    cmd
);

  mmcs_state_t       state;
  mmcs_state_t       state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] step_cnt_next;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  // Hold state and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    case (state)
      ST_IDLE: begin
        step_cnt_next = '0;
        if (src_valid && src_kind == KIND_MAP) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        step_cnt_next = step_cnt + 1'b1;
        if (status.direct || step_cnt == LAST_STEP) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    src_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        src_stall = 1'b0;
        cmd.scan  = src_valid && src_kind == KIND_SCAN;
        cmd.load  = src_valid && src_kind == KIND_MAP;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
      end
      ST_WRITE: begin
        cmd.write = status.out_free;
      end
      default: begin
        src_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/core/mmcs_dp.sv
// Datapath: running min/max, stretch setup, restoring divider and output register.
module mmcs_dp import mmcs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  mmcs_in_t     src_req,
  input  mmcs_cmd_t    cmd,
  output mmcs_status_t status,
  output logic         dst_valid,
  input  logic         dst_stall,
  output mmcs_out_t    dst_req
);

  logic [7:0]  low_seen;
  logic [7:0]  high_seen;
  logic [7:0]  span;
  logic [7:0]  rem;
  logic [7:0]  quo;
  logic        direct;
  logic [7:0]  direct_val;
  logic        last;

  logic        no_stretch;
  logic [7:0]  diff;
  logic [15:0] numer;
  logic [8:0]  trial;
  logic [8:0]  trial_sub;

  // Classify the request against the current range
  always_comb begin
    no_stretch = low_seen == 8'd0 || high_seen == FULL_SCALE || high_seen <= low_seen;
    diff       = src_req.sample - low_seen;
    numer      = {diff, 8'd0} - {8'd0, diff};
  end

  // Advance one quotient bit per step
  always_comb begin
    trial     = {rem, quo[7]};
    trial_sub = trial - {1'b0, span};
  end

  // Track min and max; restart them after the last map request of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      low_seen  <= FULL_SCALE;
      high_seen <= 8'd0;
    end else if (cmd.scan) begin
      if (src_req.sample < low_seen) begin
        low_seen <= src_req.sample;
      end
      if (src_req.sample > high_seen) begin
        high_seen <= src_req.sample;
      end
    end else if (cmd.load && src_req.frame_end) begin
      low_seen  <= FULL_SCALE;
      high_seen <= 8'd0;
    end
  end

  // Load the divider or the pass-through value, then iterate
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      span <= high_seen - low_seen;
      rem  <= numer[15:8];
      quo  <= numer[7:0];
      last <= src_req.frame_end;
      if (no_stretch) begin
        direct     <= 1'b1;
        direct_val <= src_req.sample;
      end else if (src_req.sample <= low_seen) begin
        direct     <= 1'b1;
        direct_val <= 8'd0;
      end else if (src_req.sample >= high_seen) begin
        direct     <= 1'b1;
        direct_val <= FULL_SCALE;
      end else begin
        direct     <= 1'b0;
        direct_val <= 8'd0;
      end
    end else if (cmd.step) begin
      if (!trial_sub[8]) begin
        rem <= trial_sub[7:0];
        quo <= {quo[6:0], 1'b1};
      end else begin
        rem <= trial[7:0];
        quo <= {quo[6:0], 1'b0};
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (cmd.write) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      dst_req.stretched <= direct ? direct_val : quo;
      dst_req.last_out  <= last;
    end
  end

  assign status.direct   = direct;
  assign status.out_free = !dst_valid || !dst_stall;

endmodule

>>> rtl/core/min_max_contrast_stretch.sv
// Top level of the min/max contrast stretch block.
// Usage: requests arrive on the src channel (src_valid/src_stall/src_req) and
// results leave on the dst channel (dst_valid/dst_stall/dst_req).
// A scan request (kind 0) folds its sample into the running min and max and
// gives no result; it is taken while the controller is idle.
// A map request (kind 1) gives one result: the sample stretched to the full
// 0..255 range, 0 at or below min, 255 at or above max, or passed unchanged
// when min is 0, max is 255 or max is not above min. The last
// map request of a frame (frame_end) restarts min and max for the next frame.
// A divided map request runs eight steps of the one-bit-per-cycle restoring
// divider, then the output write; one that passes through or saturates goes
// to the output write after the first divider step. No request is taken
// until the map result is written; scans are taken one per cycle when idle.
// The output register lets the next request be accepted while a result
// waits; if dst_stall stays high the datapath holds the finished result
// and src_stall stays high until the output register frees.
// Reset (rst, synchronous) empties the output and sets min 255, max 0.
module min_max_contrast_stretch import mmcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  mmcs_in_t  src_req,
  output logic      dst_valid,
  input  logic      dst_stall,
  output mmcs_out_t dst_req
);

  mmcs_cmd_t    cmd;
  mmcs_status_t status;

  mmcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_kind  (src_req.kind),
    .src_stall (src_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mmcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .src_req   (src_req),
    .cmd       (cmd),
    .status    (status),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_req   (dst_req)
  );

endmodule

>>> sim/stretch_checker.sv
// Checker for the contrast stretch block: tracks the running range and scores every result.
module stretch_checker import mmcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  input  logic      src_stall,
  input  mmcs_in_t  src_req,
  input  logic      dst_valid,
  input  logic      dst_stall,
  input  mmcs_out_t dst_req,
  output int        fail_count,
  output int        pending
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] run_min;
  logic [7:0] run_max;
  mmcs_out_t  stretched_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    $display("%0t stretch_checker: %s", $realtime, msg);
    fail_count++;
  endtask

  // Stretch one sample over the current range, or pass it through
  function automatic logic [7:0] stretch_pixel(input logic [7:0] s, input logic [7:0] lo,
                                               input logic [7:0] hi);
    logic [15:0] num;
    logic [15:0] quo;
    logic [7:0]  span;
    if (lo == 8'd0 || hi == FULL_SCALE || hi <= lo) return s;
    if (s <= lo) return 8'd0;
    if (s >= hi) return FULL_SCALE;
    span = hi - lo;
    num = ({8'd0, s} - {8'd0, lo}) * 16'd255;
    quo = num / {8'd0, span};
    if (quo > 16'd255) quo = 16'd255;
    return quo[7:0];
  endfunction

  always @(posedge clk) begin
    mmcs_out_t want;
    if (rst) begin
      run_min = FULL_SCALE;
      run_max = 8'd0;
      stretched_q.delete();
    end else begin
      // Score a delivered result against the oldest prediction
      if (dst_valid && !dst_stall) begin
        if (stretched_q.size() == 0) begin
          report_mismatch($sformatf("result stretched=%0d last=%0b with nothing expected",
                                    dst_req.stretched, dst_req.last_out));
        end else begin
          want = stretched_q.pop_front();
          if (dst_req.stretched !== want.stretched)
            report_mismatch($sformatf("stretched got %0d want %0d",
                                      dst_req.stretched, want.stretched));
          if (dst_req.last_out !== want.last_out)
            report_mismatch($sformatf("last_out got %0b want %0b",
                                      dst_req.last_out, want.last_out));
        end
      end
      // Fold scan requests into the range, predict map requests
      if (src_valid && !src_stall) begin
        if (src_req.kind == KIND_SCAN) begin
          if (src_req.sample < run_min) run_min = src_req.sample;
          if (src_req.sample > run_max) run_max = src_req.sample;
        end else begin
          want.stretched = stretch_pixel(src_req.sample, run_min, run_max);
          want.last_out = src_req.frame_end;
          stretched_q.push_back(want);
          if (src_req.frame_end) begin
            run_min = FULL_SCALE;
            run_max = 8'd0;
          end
        end
      end
    end
    pending = stretched_q.size();
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the contrast stretch block: clock, reset, request traffic and verdict.
module tb_top import mmcs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQ_TARGET  = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  mmcs_in_t  src_req = '0;
  logic      dst_valid;
  logic      dst_stall = 1'b0;
  mmcs_out_t dst_req;

  int fail_count;
  int pending;
  int sent_cnt = 0;
  int cycle_cnt = 0;
  int src_idle_pct = 37;
  int dst_idle_pct = 59;
  bit hold_off_start = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  min_max_contrast_stretch DUT (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_req   (src_req),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_req   (dst_req)
  );

  stretch_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_req    (src_req),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .dst_req    (dst_req),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Receiver: random stall, plus one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_start && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        dst_stall <= 1'b1;
        hold_left--;
      end else begin
        dst_stall <= ($urandom_range(99) < dst_idle_pct);
      end
    end
  end

  function automatic mmcs_in_t make_req(input kind_t k, input logic [7:0] s, input logic fe);
    mmcs_in_t r;
    r.kind = k;
    r.sample = s;
    r.frame_end = fe;
    return r;
  endfunction

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_request(input mmcs_in_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_req <= r;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    sent_cnt++;
  endtask

  // One frame: scans over a random range, then maps that usually end on frame_end
  task automatic run_frame();
    logic [7:0] lo_b;
    logic [7:0] hi_b;
    logic [7:0] s;
    int n_scan;
    int n_map;
    bit drop_last;
    lo_b = 8'($urandom_range(255, 0));
    hi_b = 8'($urandom_range(255, lo_b));
    if ($urandom_range(9) == 0) lo_b = 8'd0;
    if ($urandom_range(9) == 0) hi_b = 8'd255;
    n_scan = $urandom_range(10, 1);
    n_map = $urandom_range(8, 1);
    drop_last = ($urandom_range(9) == 0);
    for (int i = 0; i < n_scan; i++) begin
      s = 8'($urandom_range(hi_b, lo_b));
      send_request(make_req(KIND_SCAN, s, $urandom_range(7) == 0));
    end
    for (int i = 0; i < n_map; i++) begin
      if ($urandom_range(1)) s = 8'($urandom_range(255, 0));
      else s = 8'($urandom_range(hi_b, lo_b));
      send_request(make_req(KIND_MAP, s, (i == n_map - 1) && !drop_last));
    end
  endtask

  // Stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Map before any scan, then on a cleared range
    send_request(make_req(KIND_MAP, 8'd100, 1'b0));
    send_request(make_req(KIND_MAP, 8'd0, 1'b1));
    // Normal range, frame_end on a scan does nothing extra
    send_request(make_req(KIND_SCAN, 8'd40, 1'b0));
    send_request(make_req(KIND_SCAN, 8'd200, 1'b1));
    send_request(make_req(KIND_MAP, 8'd40, 1'b0));
    send_request(make_req(KIND_MAP, 8'd20, 1'b0));
    send_request(make_req(KIND_MAP, 8'd200, 1'b0));
    send_request(make_req(KIND_MAP, 8'd250, 1'b0));
    send_request(make_req(KIND_MAP, 8'd120, 1'b0));
    send_request(make_req(KIND_MAP, 8'd255, 1'b0));
    send_request(make_req(KIND_MAP, 8'd41, 1'b1));
    // Minimum at zero: pass through
    send_request(make_req(KIND_SCAN, 8'd0, 1'b0));
    send_request(make_req(KIND_SCAN, 8'd100, 1'b0));
    send_request(make_req(KIND_MAP, 8'd50, 1'b1));
    // Maximum at full scale: pass through
    send_request(make_req(KIND_SCAN, 8'd30, 1'b0));
    send_request(make_req(KIND_SCAN, 8'd255, 1'b0));
    send_request(make_req(KIND_MAP, 8'd128, 1'b1));
    // Empty range: pass through
    send_request(make_req(KIND_SCAN, 8'd77, 1'b0));
    send_request(make_req(KIND_MAP, 8'd77, 1'b0));
    send_request(make_req(KIND_MAP, 8'd90, 1'b1));

    // Random frames mixed with noise; idling swapped in the second third, off in the last
    while (sent_cnt < REQ_TARGET) begin
      if (sent_cnt >= 2 * REQ_TARGET / 3) begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end else if (sent_cnt >= REQ_TARGET / 3) begin
        src_idle_pct = 59;
        dst_idle_pct = 37;
        hold_off_start = 1'b1;
      end
      if ($urandom_range(99) < 85) run_frame();
      else send_request(mmcs_in_t'($urandom_range(1023, 0)));
    end
    src_valid <= 1'b0;

    // Let the checker see the last request, drain results, then settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mmcs_pkg.sv
rtl/core/mmcs_ctrl.sv
rtl/core/mmcs_dp.sv
rtl/core/min_max_contrast_stretch.sv
sim/stretch_checker.sv
sim/tb_top.sv
